/* hw/rtl/crdg_pkg.sv */
// Shared widths, register indexes, status codes and sideband type of the ray generator.
`timescale 1ns / 1ps

package crdg_pkg;

	// Widths of the transaction fields.
	localparam int PIX_W  = 11;
	localparam int DIR_W  = 16;
	localparam int BIDX_W = 22;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 63;
	localparam int IDX_W  = 3;
	localparam int VP_W   = 12;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_ROW_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROW_W = 3'd3;
	localparam logic [IDX_W-1:0] REG_VP_W  = 3'd4;
	localparam logic [IDX_W-1:0] REG_VP_H  = 3'd5;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
	localparam logic [STAT_W-1:0] ST_WZERO   = 2'd2;

	// Datapath widths.
	localparam int COEF_W  = 21;  // Q10.10 coefficient
	localparam int UV_W    = 21;  // Q1.20 viewport coordinate
	localparam int UV_FRAC = 20;
	localparam int PROD_W  = 42;
	localparam int SUM_W   = 44;
	localparam int MAG_W   = 43;
	localparam int SM_W    = 24;  // magnitude after scaling
	localparam int SH_W    = 5;   // scale shift count
	localparam int NSQ_W   = 50;
	localparam int NORM_W  = 25;
	localparam int SR_W    = 27;  // square root remainder
	localparam int DQ_W    = 15;  // direction quotient
	localparam int DD_W    = 39;  // direction dividend
	localparam int DIR_ONE = 14;  // fraction bits of the output

	// Iteration counts of the pipelined units.
	localparam int ND_STEPS = 21;
	localparam int SQ_STEPS = 25;
	localparam int DV_STEPS = 15;

	// Per-item sideband that travels with the data.
	typedef struct packed {
		logic              outside;
		logic              wzero;
		logic              nzero;
		logic [2:0]        neg;
		logic [BIDX_W-1:0] bidx;
	} side_t;

endpackage

/* hw/rtl/crdg_cfg_if.sv */
// Configuration write channel of the ray generator.
`timescale 1ns / 1ps

interface crdg_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [crdg_pkg::IDX_W-1:0]  index;
	logic [crdg_pkg::CFG_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/crdg_pix_if.sv */
// Pixel input channel of the ray generator.
`timescale 1ns / 1ps

interface crdg_pix_if;
	logic                        valid;
	logic                        ready;
	logic [crdg_pkg::PIX_W-1:0]  pixel_x;
	logic [crdg_pkg::PIX_W-1:0]  pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

/* hw/rtl/crdg_ray_if.sv */
// Ray result channel of the ray generator.
`timescale 1ns / 1ps

interface crdg_ray_if;
	logic                               valid;
	logic                               ready;
	logic signed [crdg_pkg::DIR_W-1:0]  dir_x;
	logic signed [crdg_pkg::DIR_W-1:0]  dir_y;
	logic signed [crdg_pkg::DIR_W-1:0]  dir_z;
	logic [crdg_pkg::BIDX_W-1:0]        buffer_index;
	logic [crdg_pkg::STAT_W-1:0]        status;

	modport source (output valid, output dir_x, output dir_y, output dir_z,
		output buffer_index, output status, input ready);
	modport sink   (input valid, input dir_x, input dir_y, input dir_z,
		input buffer_index, input status, output ready);
endinterface

/* hw/rtl/camera_ray_direction_generator.sv */
// Top level of the pinhole camera ray direction generator pipeline.
`timescale 1ns / 1ps

// The block takes one pixel transaction per clock and returns one ray transaction for each,
// in order. The pipeline is a single chain of registers: the input stage, a 21-step
// divider for the viewport coordinates, eight stages of matrix products, sums, magnitudes
// and scaling, a 25-step square root, a preparation stage, a 15-step divider for the three
// direction components and the output register, all advancing together. When the output
// register holds a ray that is not taken, the whole chain freezes, so the pixel ready
// follows the ray ready combinationally while the output register is full. Configuration
// writes are accepted in every cycle and must only be made while no pixel is in flight.
module camera_ray_direction_generator #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	crdg_cfg_if.sink    cfg,
	crdg_pix_if.sink    pix,
	crdg_ray_if.source  ray
);

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int WH   = $clog2(MAX_HEIGHT + 1);
	localparam int XW0  = (WW > WH) ? WW : WH;
	localparam int XW   = (XW0 > crdg_pkg::VP_W) ? XW0 : crdg_pkg::VP_W;
	localparam int XW2  = 2 * XW;

	localparam int UVW  = crdg_pkg::UV_W;
	localparam int SUMW = crdg_pkg::SUM_W;
	localparam int MAGW = crdg_pkg::MAG_W;
	localparam int SMW  = crdg_pkg::SM_W;
	localparam int SHW  = crdg_pkg::SH_W;
	localparam int NSQW = crdg_pkg::NSQ_W;
	localparam int NRMW = crdg_pkg::NORM_W;
	localparam int SRW  = crdg_pkg::SR_W;
	localparam int DQW  = crdg_pkg::DQ_W;
	localparam int DDW  = crdg_pkg::DD_W;
	localparam int DIRW = crdg_pkg::DIR_W;
	localparam int BIW  = crdg_pkg::BIDX_W;
	localparam int NDS  = crdg_pkg::ND_STEPS;
	localparam int SQS  = crdg_pkg::SQ_STEPS;
	localparam int DVS  = crdg_pkg::DV_STEPS;

	// Input stage, divider, eight stages, root, preparation, divider, output register.
	localparam int NST  = 1 + NDS + 8 + SQS + 1 + DVS + 1;

	// ---------------------------------------------------------------------
	// Configuration registers. The interface always takes a write.
	// ---------------------------------------------------------------------
	logic [crdg_pkg::CFG_W-1:0] coef_q [4];
	logic [crdg_pkg::VP_W-1:0]  vw_q;
	logic [crdg_pkg::VP_W-1:0]  vh_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) coef_q[r] <= '0;
			vw_q <= 12'd1;
			vh_q <= 12'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				crdg_pkg::REG_ROW_X: coef_q[0] <= cfg.data;
				crdg_pkg::REG_ROW_Y: coef_q[1] <= cfg.data;
				crdg_pkg::REG_ROW_Z: coef_q[2] <= cfg.data;
				crdg_pkg::REG_ROW_W: coef_q[3] <= cfg.data;
				crdg_pkg::REG_VP_W:  vw_q <= cfg.data[crdg_pkg::VP_W-1:0];
				crdg_pkg::REG_VP_H:  vh_q <= cfg.data[crdg_pkg::VP_W-1:0];
				default: ;
			endcase
		end
	end

	// Viewport size limited to the supported maximum.
	logic [XW-1:0] w_cl;
	logic [XW-1:0] h_cl;
	assign w_cl = (XW'(vw_q) > XW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)  : XW'(vw_q);
	assign h_cl = (XW'(vh_q) > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : XW'(vh_q);

	// ---------------------------------------------------------------------
	// Flow control: every stage advances together unless the output
	// register holds a ray that is not being taken.
	// ---------------------------------------------------------------------
	logic [NST-1:0] vld_q;
	logic           adv;
	logic           in_acc;

	assign adv       = !vld_q[NST-1] || ray.ready;
	assign pix.ready = adv;
	assign in_acc    = pix.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_acc};
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: bounds check, buffer index and the magnitudes |2p - n|.
	// ---------------------------------------------------------------------
	logic [XW-1:0]   px_x;
	logic [XW-1:0]   py_x;
	logic [XW:0]     twop_x;
	logic [XW:0]     twop_y;
	logic [XW-1:0]   hm;
	logic [XW2-1:0]  prod_bi;
	logic            in_neg_u;
	logic            in_neg_v;
	logic [XW:0]     in_mag_u;
	logic [XW:0]     in_mag_v;
	crdg_pkg::side_t in_side;

	always_comb begin
		px_x     = XW'(pix.pixel_x);
		py_x     = XW'(pix.pixel_y);
		twop_x   = {px_x, 1'b0};
		twop_y   = {py_x, 1'b0};
		in_neg_u = twop_x < {1'b0, w_cl};
		in_neg_v = twop_y < {1'b0, h_cl};
		in_mag_u = in_neg_u ? ({1'b0, w_cl} - twop_x) : (twop_x - {1'b0, w_cl});
		in_mag_v = in_neg_v ? ({1'b0, h_cl} - twop_y) : (twop_y - {1'b0, h_cl});
		hm       = h_cl - XW'(1) - py_x;
		prod_bi  = XW2'(hm) * XW2'(w_cl) + XW2'(px_x);
		in_side         = '0;
		in_side.outside = !((px_x < w_cl) && (py_x < h_cl));
		in_side.bidx    = prod_bi[BIW-1:0];
	end

	logic [XW:0]     mag_u_s1;
	logic [XW:0]     mag_v_s1;
	logic            neg_u_s1;
	logic            neg_v_s1;
	crdg_pkg::side_t side_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_u_s1 <= in_mag_u;
			mag_v_s1 <= in_mag_v;
			neg_u_s1 <= in_neg_u;
			neg_v_s1 <= in_neg_v;
			side_s1  <= in_side;
		end
	end

	// ---------------------------------------------------------------------
	// Viewport coordinate dividers: |2p - n| * 2^20 / n, one quotient bit
	// per stage. The remainder starts at |2p - n| / 2, which stays below n
	// for a pixel inside the viewport; the low bit enters on the first step.
	// ---------------------------------------------------------------------
	logic [XW:0]     ndu_rem_s [NDS];
	logic [XW:0]     ndv_rem_s [NDS];
	logic [UVW-1:0]  ndu_q_s   [NDS];
	logic [UVW-1:0]  ndv_q_s   [NDS];
	logic            ndu_neg_s [NDS];
	logic            ndv_neg_s [NDS];
	crdg_pkg::side_t nd_side_s [NDS];

	for (genvar j = 0; j < NDS; j++) begin : g_nd
		logic [XW:0]     ru_p;
		logic [XW:0]     rv_p;
		logic            bu;
		logic            bv;
		logic [UVW-1:0]  qu_p;
		logic [UVW-1:0]  qv_p;
		logic            nu_p;
		logic            nv_p;
		crdg_pkg::side_t sd_p;
		logic [XW+1:0]   su;
		logic [XW+1:0]   sv;
		logic            ge_u;
		logic            ge_v;

		if (j == 0) begin : g_first
			assign ru_p = {1'b0, mag_u_s1[XW:1]};
			assign rv_p = {1'b0, mag_v_s1[XW:1]};
			assign bu   = mag_u_s1[0];
			assign bv   = mag_v_s1[0];
			assign qu_p = '0;
			assign qv_p = '0;
			assign nu_p = neg_u_s1;
			assign nv_p = neg_v_s1;
			assign sd_p = side_s1;
		end else begin : g_next
			assign ru_p = ndu_rem_s[j-1];
			assign rv_p = ndv_rem_s[j-1];
			assign bu   = 1'b0;
			assign bv   = 1'b0;
			assign qu_p = ndu_q_s[j-1];
			assign qv_p = ndv_q_s[j-1];
			assign nu_p = ndu_neg_s[j-1];
			assign nv_p = ndv_neg_s[j-1];
			assign sd_p = nd_side_s[j-1];
		end

		assign su   = {ru_p, bu};
		assign sv   = {rv_p, bv};
		assign ge_u = su >= (XW+2)'(w_cl);
		assign ge_v = sv >= (XW+2)'(h_cl);

		always_ff @(posedge clk) begin
			if (adv) begin
				ndu_rem_s[j] <= ge_u ? (XW+1)'(su - (XW+2)'(w_cl)) : (XW+1)'(su);
				ndv_rem_s[j] <= ge_v ? (XW+1)'(sv - (XW+2)'(h_cl)) : (XW+1)'(sv);
				ndu_q_s[j]   <= {qu_p[UVW-2:0], ge_u};
				ndv_q_s[j]   <= {qv_p[UVW-2:0], ge_v};
				ndu_neg_s[j] <= nu_p;
				ndv_neg_s[j] <= nv_p;
				nd_side_s[j] <= sd_p;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: signed coordinates. A negative value rounds toward minus
	// infinity, so the quotient magnitude is rounded up before negation.
	// ---------------------------------------------------------------------
	logic [UVW:0] qc_u;
	logic [UVW:0] qc_v;
	assign qc_u = {1'b0, ndu_q_s[NDS-1]} + (UVW+1)'(|ndu_rem_s[NDS-1]);
	assign qc_v = {1'b0, ndv_q_s[NDS-1]} + (UVW+1)'(|ndv_rem_s[NDS-1]);

	logic signed [UVW-1:0] u_s2;
	logic signed [UVW-1:0] v_s2;
	crdg_pkg::side_t       side_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s2    <= ndu_neg_s[NDS-1] ? UVW'(-qc_u) : ndu_q_s[NDS-1];
			v_s2    <= ndv_neg_s[NDS-1] ? UVW'(-qc_v) : ndv_q_s[NDS-1];
			side_s2 <= nd_side_s[NDS-1];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: the eight coefficient products, one multiplier per term.
	// ---------------------------------------------------------------------
	logic signed [crdg_pkg::PROD_W-1:0] pu_s3 [4];
	logic signed [crdg_pkg::PROD_W-1:0] pv_s3 [4];
	crdg_pkg::side_t                    side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				pu_s3[r] <= $signed(coef_q[r][20:0]) * u_s2;
				pv_s3[r] <= $signed(coef_q[r][41:21]) * v_s2;
			end
			side_s3 <= side_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: row sums, exact in Q.30.
	// ---------------------------------------------------------------------
	logic signed [SUMW-1:0] comp_s4 [4];
	crdg_pkg::side_t        side_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				comp_s4[r] <= SUMW'(pu_s3[r]) + SUMW'(pv_s3[r])
					+ (SUMW'($signed(coef_q[r][62:42])) <<< crdg_pkg::UV_FRAC);
			end
			side_s4 <= side_s3;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: magnitudes, and signs already flipped by the sign of w.
	// ---------------------------------------------------------------------
	crdg_pkg::side_t sd5_n;

	always_comb begin
		sd5_n = side_s4;
		for (int i = 0; i < 3; i++) begin
			sd5_n.neg[i] = comp_s4[i][SUMW-1] ^ comp_s4[3][SUMW-1];
		end
		sd5_n.wzero = comp_s4[3] == '0;
	end

	logic [MAGW-1:0] mag_s5 [3];
	crdg_pkg::side_t side_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= sd5_n;
			for (int i = 0; i < 3; i++) begin
				mag_s5[i] <= comp_s4[i][SUMW-1] ? MAGW'(-comp_s4[i]) : MAGW'(comp_s4[i]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 6: largest magnitude and the shift that brings it below 2^24.
	// ---------------------------------------------------------------------
	logic [MAGW-1:0] mmax;
	logic [SHW-1:0]  shc;

	always_comb begin
		mmax = mag_s5[0];
		if (mag_s5[1] > mmax) mmax = mag_s5[1];
		if (mag_s5[2] > mmax) mmax = mag_s5[2];
		shc = '0;
		for (int k = 0; k < MAGW - SMW; k++) begin
			if ((mmax >> (SMW + k)) != '0) shc = shc + 1'b1;
		end
	end

	logic [MAGW-1:0] mag_s6 [3];
	logic [SHW-1:0]  sh_s6;
	crdg_pkg::side_t side_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s6  <= mag_s5;
			sh_s6   <= shc;
			side_s6 <= side_s5;
		end
	end

	// Stage 7: scaled magnitudes.
	logic [SMW-1:0]  sm_s7 [3];
	crdg_pkg::side_t side_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) sm_s7[i] <= SMW'(mag_s6[i] >> sh_s6);
			side_s7 <= side_s6;
		end
	end

	// Stage 8: squares.
	logic [2*SMW-1:0] sq_s8 [3];
	logic [SMW-1:0]   sm_s8 [3];
	crdg_pkg::side_t  side_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) sq_s8[i] <= sm_s7[i] * sm_s7[i];
			sm_s8   <= sm_s7;
			side_s8 <= side_s7;
		end
	end

	// Stage 9: sum of squares.
	logic [NSQW-1:0] nsq_s9;
	logic [SMW-1:0]  sm_s9 [3];
	crdg_pkg::side_t side_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			nsq_s9  <= NSQW'(sq_s8[0]) + NSQW'(sq_s8[1]) + NSQW'(sq_s8[2]);
			sm_s9   <= sm_s8;
			side_s9 <= side_s8;
		end
	end

	// ---------------------------------------------------------------------
	// Square root: one root bit per stage, two radicand bits consumed each.
	// ---------------------------------------------------------------------
	logic [SRW-1:0]  sq_rem_s  [SQS];
	logic [NRMW-1:0] sq_root_s [SQS];
	logic [NSQW-1:0] sq_n_s    [SQS];
	logic [SMW-1:0]  sq_sm_s   [SQS][3];
	crdg_pkg::side_t sq_side_s [SQS];

	for (genvar j = 0; j < SQS; j++) begin : g_sq
		localparam int PI = SQS - 1 - j;
		logic [SRW-1:0]  rem_p;
		logic [NRMW-1:0] root_p;
		logic [NSQW-1:0] n_p;
		logic [SMW-1:0]  sm_p [3];
		crdg_pkg::side_t sd_p;
		logic [SRW+1:0]  rs;
		logic [SRW+1:0]  tr;
		logic            ge;

		if (j == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign n_p    = nsq_s9;
			assign sm_p   = sm_s9;
			assign sd_p   = side_s9;
		end else begin : g_next
			assign rem_p  = sq_rem_s[j-1];
			assign root_p = sq_root_s[j-1];
			assign n_p    = sq_n_s[j-1];
			assign sm_p   = sq_sm_s[j-1];
			assign sd_p   = sq_side_s[j-1];
		end

		assign rs = {rem_p, n_p[2*PI+1:2*PI]};
		assign tr = (SRW+2)'({root_p, 2'b01});
		assign ge = rs >= tr;

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[j]  <= ge ? SRW'(rs - tr) : SRW'(rs);
				sq_root_s[j] <= {root_p[NRMW-2:0], ge};
				sq_n_s[j]    <= n_p;
				sq_sm_s[j]   <= sm_p;
				sq_side_s[j] <= sd_p;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 10: dividends mag * 2^14 + norm / 2 for rounding half up.
	// ---------------------------------------------------------------------
	crdg_pkg::side_t sd10_n;

	always_comb begin
		sd10_n       = sq_side_s[SQS-1];
		sd10_n.nzero = sq_root_s[SQS-1] == '0;
	end

	logic [DDW-1:0]  dd_s10 [3];
	logic [NRMW-1:0] norm_s10;
	crdg_pkg::side_t side_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dd_s10[i] <= DDW'({sq_sm_s[SQS-1][i], {crdg_pkg::DIR_ONE{1'b0}}})
					+ DDW'(sq_root_s[SQS-1] >> 1);
			end
			norm_s10 <= sq_root_s[SQS-1];
			side_s10 <= sd10_n;
		end
	end

	// ---------------------------------------------------------------------
	// Direction dividers: three lanes, one quotient bit per stage. The
	// quotient never exceeds 2^14, so the upper dividend bits start as the
	// remainder, already below the norm.
	// ---------------------------------------------------------------------
	logic [NRMW-1:0] dv_rem_s  [DVS][3];
	logic [DQW-1:0]  dv_q_s    [DVS][3];
	logic [DDW-1:0]  dv_dd_s   [DVS][3];
	logic [NRMW-1:0] dv_norm_s [DVS];
	crdg_pkg::side_t dv_side_s [DVS];

	for (genvar j = 0; j < DVS; j++) begin : g_dv
		logic [NRMW-1:0] rem_p [3];
		logic [DQW-1:0]  q_p   [3];
		logic [DDW-1:0]  dd_p  [3];
		logic [NRMW-1:0] norm_p;
		crdg_pkg::side_t sd_p;

		if (j == 0) begin : g_first
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_p[i] = NRMW'(dd_s10[i][DDW-1:DQW]);
				assign q_p[i]   = '0;
			end
			assign dd_p   = dd_s10;
			assign norm_p = norm_s10;
			assign sd_p   = side_s10;
		end else begin : g_next
			assign rem_p  = dv_rem_s[j-1];
			assign q_p    = dv_q_s[j-1];
			assign dd_p   = dv_dd_s[j-1];
			assign norm_p = dv_norm_s[j-1];
			assign sd_p   = dv_side_s[j-1];
		end

		for (genvar i = 0; i < 3; i++) begin : g_step
			logic [NRMW:0] rs;
			logic          ge;
			assign rs = {rem_p[i], dd_p[i][DQW-1-j]};
			assign ge = rs >= {1'b0, norm_p};

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[j][i] <= ge ? NRMW'(rs - {1'b0, norm_p}) : NRMW'(rs);
					dv_q_s[j][i]   <= {q_p[i][DQW-2:0], ge};
					dv_dd_s[j][i]  <= dd_p[i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_norm_s[j] <= norm_p;
				dv_side_s[j] <= sd_p;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output register: signs applied and special cases resolved. A pixel
	// outside the viewport gives only its status; a zero w still gives the
	// buffer index; a zero direction gives zeros with an ok status.
	// ---------------------------------------------------------------------
	crdg_pkg::side_t sd_o;
	logic            dir_off;
	logic [DIRW-1:0] d_o [3];

	always_comb begin
		sd_o    = dv_side_s[DVS-1];
		dir_off = sd_o.outside || sd_o.wzero || sd_o.nzero;
		for (int i = 0; i < 3; i++) begin
			if (dir_off) begin
				d_o[i] = '0;
			end else if (sd_o.neg[i]) begin
				d_o[i] = -DIRW'(dv_q_s[DVS-1][i]);
			end else begin
				d_o[i] = DIRW'(dv_q_s[DVS-1][i]);
			end
		end
	end

	logic [DIRW-1:0]              dirx_s11;
	logic [DIRW-1:0]              diry_s11;
	logic [DIRW-1:0]              dirz_s11;
	logic [BIW-1:0]               bidx_s11;
	logic [crdg_pkg::STAT_W-1:0]  stat_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			dirx_s11 <= d_o[0];
			diry_s11 <= d_o[1];
			dirz_s11 <= d_o[2];
			bidx_s11 <= sd_o.outside ? '0 : sd_o.bidx;
			if (sd_o.outside) begin
				stat_s11 <= crdg_pkg::ST_OUTSIDE;
			end else if (sd_o.wzero) begin
				stat_s11 <= crdg_pkg::ST_WZERO;
			end else begin
				stat_s11 <= crdg_pkg::ST_OK;
			end
		end
	end

	assign ray.valid        = vld_q[NST-1];
	assign ray.dir_x        = dirx_s11;
	assign ray.dir_y        = diry_s11;
	assign ray.dir_z        = dirz_s11;
	assign ray.buffer_index = bidx_s11;
	assign ray.status       = stat_s11;

`ifndef SYNTHESIS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid |-> (ray.status == crdg_pkg::ST_OK || ray.status == crdg_pkg::ST_OUTSIDE
			|| ray.status == crdg_pkg::ST_WZERO))
		else $error("ray status carries an unused code");

	a_outside_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid && ray.status == crdg_pkg::ST_OUTSIDE |->
			ray.buffer_index == '0 && ray.dir_x == '0 && ray.dir_y == '0 && ray.dir_z == '0)
		else $error("outside pixel produced a nonzero ray");

	a_dir_unit: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid && ray.status == crdg_pkg::ST_OK |->
			ray.dir_x <= 16'sd16384 && ray.dir_x >= -16'sd16384 &&
			ray.dir_y <= 16'sd16384 && ray.dir_y >= -16'sd16384 &&
			ray.dir_z <= 16'sd16384 && ray.dir_z >= -16'sd16384)
		else $error("direction component exceeds unit length");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!ray.valid |-> pix.ready)
		else $error("pixel input stalled with an empty output register");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready |=> vld_q[0])
		else $error("accepted pixel did not enter the pipeline");
`endif

endmodule
